### sv/stmin_pkg.sv
package stmin_pkg;

    localparam int LEAVES     = 1024;
    localparam int NODE_COUNT = 4 * LEAVES;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int POS_W      = 10;
    localparam int IDX_W      = 11;
    localparam int VAL_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [0:0] OP_INSERT = 1'b0;
    localparam logic [0:0] OP_QUERY  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LEAF_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE = 2'd1;

    typedef struct packed {
        logic [0:0]              op;
        logic [POS_W-1:0]        first_index;
        logic [POS_W-1:0]        last_index;
        logic signed [VAL_W-1:0] new_value;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0]        min_index;
        logic signed [VAL_W-1:0] min_value;
    } t_out;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] val;
    } t_node;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [POS_W-1:0]  b;
        logic [POS_W-1:0]  e;
    } t_walk;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_IDESC,
        S_IUPD,
        S_QDESC,
        S_QMRG
    } t_state;

endpackage

### sv/segment_tree_range_min.sv
// segment tree range minimum over up to 1024 leaves, node store in one ram
// command channel: item taken on a clock edge with start high and busy low
//   op insert: lowers leaf first_index to new_value if strictly smaller,
//     then walks up to the root; no result transaction
//   op query: min over [first_index, last_index], one result transaction
// result: o_done high for exactly one cycle with o_result; receiver cannot stall
// config: i_cfg_we/i_cfg_idx/i_cfg_data, written only while idle; a write to
//   leaf_count or init_value restarts the clearing pass, other indexes ignored
// clearing pass: after reset and after each such config write, busy high
// insert: descends to the leaf (depth <= 10), then climbs back to the root
// query: per covering node a walk from the root (S_QDESC) plus one merge
//   step (S_QMRG); a range breaks into at most about 20 covering nodes
// empty or out-of-range query answers the cycle after it is taken
module segment_tree_range_min
    import stmin_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in                   i_in,
    output logic                  o_done,
    output t_out                  o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [IDX_W-1:0]        r_leaf_count;
    logic signed [VAL_W-1:0] r_init;
    logic [NODE_W-1:0]       r_cnt, n_cnt;
    t_walk                   r_walk, n_walk;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic [POS_W-1:0]        r_hi, n_hi;
    t_node                   r_acc, n_acc;
    logic                    r_done, n_done;
    t_out                    r_out, n_out;

    logic [IDX_W-1:0]  used;
    logic [POS_W-1:0]  top;
    t_node             sentinel;
    logic              cfg_hit;
    logic              q_empty;
    logic              ins_ok;
    logic              q_hit;
    logic [NODE_W-1:0] parent;
    t_walk             step;
    t_walk             root;
    t_node             rd_node;
    t_node             merged;

    logic              mem_we;
    logic [NODE_W-1:0] mem_waddr;
    t_node             mem_wdata;
    logic [NODE_W-1:0] mem_raddr;
    logic [IDX_W+VAL_W-1:0] mem_rdata;

    // leaf count above the tree size acts as the full tree
    assign used     = (r_leaf_count > IDX_W'(LEAVES)) ? IDX_W'(LEAVES) : r_leaf_count;
    assign top      = POS_W'(used - 1'b1);
    assign sentinel = '{idx: used + 1'b1, val: r_init};
    assign cfg_hit  = i_cfg_we &&
                      (i_cfg_idx == REG_LEAF_COUNT || i_cfg_idx == REG_INIT_VALUE);
    assign q_empty  = (used == '0) || (i_in.first_index > i_in.last_index) ||
                      (i_in.first_index > top);
    assign ins_ok   = {1'b0, i_in.first_index} < used;
    assign q_hit    = (r_walk.b == r_pos) && (r_walk.e <= r_hi);
    assign parent   = (r_walk.node - 1'b1) >> 1;
    assign root     = '{node: '0, b: '0, e: top};
    assign rd_node  = t_node'(mem_rdata);

    // a stored pair with value init_value is always the sentinel, so a query
    // is the rightmost smallest non-empty covering node
    always_comb begin
        merged = r_acc;
        if (rd_node.val != r_init &&
            (r_acc.val == r_init || rd_node.val <= r_acc.val)) begin
            merged = rd_node;
        end
    end

    stmin_step u_step (
        .i_cur  (r_walk),
        .i_pos  (r_pos),
        .o_next (step)
    );

    stmin_ram #(
        .WIDTH (IDX_W + VAL_W),
        .DEPTH (NODE_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_cnt == NODE_W'(NODE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_in.op == OP_INSERT) begin
                        if (ins_ok) begin
                            n_state = S_IDESC;
                        end
                    end else if (!q_empty) begin
                        n_state = S_QDESC;
                    end
                end
            end
            S_IDESC: begin
                if (r_walk.b == r_walk.e) begin
                    n_state = S_IUPD;
                end
            end
            S_IUPD: begin
                if (r_walk.node == '0) begin
                    n_state = S_IDLE;
                end
            end
            S_QDESC: begin
                if (q_hit) begin
                    n_state = S_QMRG;
                end
            end
            S_QMRG: begin
                n_state = (r_walk.e >= r_hi) ? S_IDLE : S_QDESC;
            end
            default: n_state = S_CLEAR;
        endcase
        if (cfg_hit) begin
            n_state = S_CLEAR;
        end
    end

    // datapath and ram control
    always_comb begin
        n_cnt     = r_cnt;
        n_walk    = r_walk;
        n_pos     = r_pos;
        n_hi      = r_hi;
        n_acc     = r_acc;
        n_done    = 1'b0;
        n_out     = r_out;
        mem_we    = 1'b0;
        mem_waddr = r_walk.node;
        mem_wdata = r_acc;
        mem_raddr = r_walk.node;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = sentinel;
                n_cnt     = r_cnt + 1'b1;
            end
            S_IDLE: begin
                if (start) begin
                    n_walk = root;
                    n_pos  = i_in.first_index;
                    n_hi   = (i_in.last_index > top) ? top : i_in.last_index;
                    if (i_in.op == OP_INSERT) begin
                        n_acc = '{idx: {1'b0, i_in.first_index}, val: i_in.new_value};
                    end else begin
                        n_acc = sentinel;
                        if (q_empty) begin
                            n_done = 1'b1;
                            n_out  = '{min_index: sentinel.idx, min_value: sentinel.val};
                        end
                    end
                end
            end
            S_IDESC: begin
                if (r_walk.b != r_walk.e) begin
                    n_walk = step;
                end
            end
            S_IUPD: begin
                // carry the node's final pair upward, strictly smaller wins
                if (r_acc.val < rd_node.val) begin
                    mem_we = 1'b1;
                end else begin
                    n_acc = rd_node;
                end
                mem_raddr   = parent;
                n_walk.node = parent;
            end
            S_QDESC: begin
                if (!q_hit) begin
                    n_walk = step;
                end
            end
            S_QMRG: begin
                n_acc = merged;
                if (r_walk.e >= r_hi) begin
                    n_done = 1'b1;
                    n_out  = '{min_index: merged.idx, min_value: merged.val};
                end else begin
                    n_pos  = r_walk.e + 1'b1;
                    n_walk = root;
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
        if (cfg_hit) begin
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_cnt        <= '0;
            r_done       <= 1'b0;
            r_leaf_count <= IDX_W'(LEAVES);
            r_init       <= 32'sh7fff_ffff;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
            if (i_cfg_we && i_cfg_idx == REG_LEAF_COUNT) begin
                r_leaf_count <= i_cfg_data[IDX_W-1:0];
            end
            if (i_cfg_we && i_cfg_idx == REG_INIT_VALUE) begin
                r_init <= $signed(i_cfg_data[VAL_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk <= n_walk;
        r_pos  <= n_pos;
        r_hi   <= n_hi;
        r_acc  <= n_acc;
        r_out  <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

endmodule

### sv/stmin_ram.sv
module stmin_ram #(
    parameter int WIDTH = 43,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/stmin_step.sv
module stmin_step
    import stmin_pkg::*;
(
    input  t_walk            i_cur,
    input  logic [POS_W-1:0] i_pos,
    output t_walk            o_next
);

    logic [POS_W-1:0] mid;

    // midpoint split, child that holds the target leaf
    always_comb begin
        mid = i_cur.b + ((i_cur.e - i_cur.b) >> 1);
        if (i_pos <= mid) begin
            o_next.node = NODE_W'({i_cur.node, 1'b0} + 1'b1);
            o_next.b    = i_cur.b;
            o_next.e    = mid;
        end else begin
            o_next.node = NODE_W'({i_cur.node, 1'b0} + 2'd2);
            o_next.b    = mid + 1'b1;
            o_next.e    = i_cur.e;
        end
    end

endmodule

### test/tb_segment_tree_range_min.sv
module tb_segment_tree_range_min
    import stmin_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // scoreboard: own copy of the tree nodes plus a queue of expected answers
    class MinScoreboard;
        int unsigned leaves_used;
        logic signed [VAL_W-1:0] empty_val;
        t_node nodes[NODE_COUNT];
        t_out pending_answers[$];
        int mismatch_count;

        function void clear_tree(int unsigned lc, logic signed [VAL_W-1:0] iv);
            t_node s;
            leaves_used = (lc > LEAVES) ? LEAVES : lc;
            empty_val = iv;
            s.idx = IDX_W'(leaves_used + 1);
            s.val = iv;
            foreach (nodes[i]) nodes[i] = s;
        endfunction

        function t_node blank();
            t_node s;
            s.idx = IDX_W'(leaves_used + 1);
            s.val = empty_val;
            return s;
        endfunction

        function t_node lower_leaf(int unsigned nd, int b, int e, int pos,
                                   logic signed [VAL_W-1:0] v);
            t_node r;
            int m;
            if (nd >= NODE_COUNT || pos < b || pos > e) return blank();
            if (b == e) begin
                if (v < nodes[nd].val) begin
                    nodes[nd].idx = IDX_W'(pos);
                    nodes[nd].val = v;
                end
                return nodes[nd];
            end
            m = b + (e - b) / 2;
            if (pos <= m) r = lower_leaf(nd * 2 + 1, b, m, pos, v);
            else r = lower_leaf(nd * 2 + 2, m + 1, e, pos, v);
            if (r.val < nodes[nd].val) nodes[nd] = r;
            return nodes[nd];
        endfunction

        function t_node range_min(int unsigned nd, int b, int e, int lo, int hi);
            t_node l;
            t_node r;
            int m;
            if (nd >= NODE_COUNT || b > e || lo > e || hi < b) return blank();
            if (b >= lo && e <= hi) return nodes[nd];
            m = b + (e - b) / 2;
            l = range_min(nd * 2 + 1, b, m, lo, hi);
            r = range_min(nd * 2 + 2, m + 1, e, lo, hi);
            // empty marker yields, otherwise ties go right
            if (l.val == empty_val) return r;
            if (r.val == empty_val) return l;
            return (l.val < r.val) ? l : r;
        endfunction

        function void note_command(t_in c);
            t_node res;
            t_out o;
            if (c.op == OP_INSERT) begin
                if (c.first_index < leaves_used)
                    res = lower_leaf(0, 0, int'(leaves_used) - 1, int'(c.first_index),
                                     c.new_value);
            end else begin
                res = range_min(0, 0, int'(leaves_used) - 1, int'(c.first_index),
                                int'(c.last_index));
                o.min_index = res.idx;
                o.min_value = res.val;
                pending_answers.insert(pending_answers.size(), o);
            end
        endfunction

        task report_mismatch(string what, t_out got, t_out want);
            $display("mismatch: %s got idx %0d val %0d want idx %0d val %0d",
                     what, got.min_index, got.min_value, want.min_index,
                     want.min_value);
            mismatch_count++;
        endtask

        task check_answer(t_out got);
            t_out want;
            if (pending_answers.size() == 0) begin
                report_mismatch("answer with none pending", got, got);
                return;
            end
            want = pending_answers.pop_front();
            if (got.min_index !== want.min_index || got.min_value !== want.min_value) begin
                report_mismatch("answer mismatch", got, want);
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in i_in;
    logic o_done;
    t_out o_result;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    MinScoreboard sb;
    longint cycle_count = 0;
    int unsigned cur_leaves;

    segment_tree_range_min u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_in(i_in), .o_done(o_done), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: clearing passes plus worst-case walks, taken several times over
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result monitor: strobe is sampled on the edge that ends its cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_answer(o_result);
    end

    // one transaction on the command port, with a random gap in front
    task automatic send_command(t_in c);
        int gap;
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // accepted at this edge
        sb.note_command(c);
    endtask

    // wait for answers to drain, then let a trailing insert finish its walk
    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (sb.pending_answers.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [CFG_DATA_W-1:0] d);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= ri;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (ri == REG_LEAF_COUNT) begin
            cur_leaves = d[IDX_W-1:0];
            sb.clear_tree(d[IDX_W-1:0], sb.empty_val);
        end else if (ri == REG_INIT_VALUE) begin
            sb.clear_tree(cur_leaves, d);
        end
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic t_in make_cmd(logic op, int f, int l, int v);
        t_in c;
        c.op = op;
        c.first_index = POS_W'(f);
        c.last_index = POS_W'(l);
        c.new_value = v;
        return c;
    endfunction

    // random content aimed at leaves in use, with some noise past the end
    function automatic t_in rand_cmd(int unsigned lc, logic signed [VAL_W-1:0] iv);
        t_in c;
        int lim;
        int a;
        int b;
        lim = (lc == 0) ? 0 : ((lc > LEAVES) ? LEAVES - 1 : lc - 1);
        c.first_index = POS_W'($urandom);
        c.last_index = POS_W'($urandom);
        c.op = ($urandom_range(0, 9) < 5) ? OP_INSERT : OP_QUERY;
        if ($urandom_range(0, 9) != 0) begin
            a = $urandom_range(0, lim);
            b = $urandom_range(0, lim);
            if ($urandom_range(0, 7) != 0 && a > b) begin
                c.first_index = POS_W'(b);
                c.last_index = POS_W'(a);
            end else begin
                c.first_index = POS_W'(a);
                c.last_index = POS_W'(b);
            end
        end
        case ($urandom_range(0, 7))
            0: c.new_value = iv;
            1: c.new_value = $urandom_range(0, 8) - 4;
            2: c.new_value = 32'sh80000000 + $urandom_range(0, 3);
            3: c.new_value = 32'sh7fffffff - $urandom_range(0, 3);
            4: c.new_value = iv - $urandom_range(0, 20);
            default: c.new_value = $urandom;
        endcase
        return c;
    endfunction

    task automatic run_phase(int unsigned lc, logic [31:0] iv, int count);
        write_reg(REG_LEAF_COUNT, lc);
        write_reg(REG_INIT_VALUE, iv);
        repeat (count) send_command(rand_cmd(lc, iv));
    endtask

    initial begin
        sb = new();
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_in <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        cur_leaves = 1024;
        sb.clear_tree(1024, 32'sh7fffffff);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // directed: reset settings, extremes, ties, empty and past-the-end ranges
        send_command(make_cmd(OP_QUERY, 0, 1023, 0));
        send_command(make_cmd(OP_INSERT, 0, 0, 32'sh80000000));
        send_command(make_cmd(OP_INSERT, 1023, 1023, -5));
        send_command(make_cmd(OP_INSERT, 512, 0, -5));
        send_command(make_cmd(OP_INSERT, 512, 0, -6));
        send_command(make_cmd(OP_INSERT, 513, 1023, 32'sh7fffffff));
        send_command(make_cmd(OP_QUERY, 0, 1023, 0));
        send_command(make_cmd(OP_QUERY, 1, 1023, 0));
        send_command(make_cmd(OP_QUERY, 600, 1023, 0));
        send_command(make_cmd(OP_QUERY, 1023, 0, 0));
        send_command(make_cmd(OP_QUERY, 513, 513, 0));
        write_reg(REG_LEAF_COUNT, 0);
        send_command(make_cmd(OP_INSERT, 0, 0, -1));
        send_command(make_cmd(OP_QUERY, 0, 1023, 0));
        write_reg(REG_LEAF_COUNT, 11'h7ff);
        send_command(make_cmd(OP_INSERT, 1023, 0, 3));
        send_command(make_cmd(OP_QUERY, 0, 1023, 0));
        write_reg(REG_LEAF_COUNT, 5);
        send_command(make_cmd(OP_INSERT, 7, 0, -9));
        send_command(make_cmd(OP_INSERT, 4, 0, -9));
        send_command(make_cmd(OP_QUERY, 3, 900, 0));
        send_command(make_cmd(OP_QUERY, 6, 900, 0));
        write_reg(REG_UNUSED, 32'd17);
        send_command(make_cmd(OP_QUERY, 0, 4, 0));

        // random phases over several settings, extremes among them
        run_phase(1, 32'sh80000000, 60);
        run_phase(2, 0, 80);
        run_phase(7, 32'sh7fffffff, 120);
        run_phase(16, -3, 120);
        run_phase($urandom_range(3, 100), $urandom, 150);
        run_phase(1024, 32'sh7fffffff, 150);
        run_phase(2047, 100, 60);
        run_phase(0, 5, 20);
        run_phase(33, 32'sh80000001, 60);

        drain();
        if (sb.pending_answers.size() != 0) begin
            sb.report_mismatch("answers never arrived", '0, sb.pending_answers[0]);
        end
        if (sb.mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
